/* design/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes and the result record of the go-back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Default sizing of the window, the sequence space and the packet limit
  localparam int DEF_WINDOW_DEPTH = 4;
  localparam int DEF_SEQ_MAX      = 7;
  localparam int DEF_PAYLOAD_MAX  = 256;

  // Fixed field widths of the stream items
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int ASEQ_W  = 3;
  localparam int KIND_W  = 2;
  localparam int FSEQ_W  = 3;
  localparam int CSUM_W  = 17;
  localparam int FSLOT_W = 2;
  localparam int FREED_W = 3;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK_OK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_IGN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd3;

  // One result beat as produced by the controller
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FSEQ_W-1:0]  seq;
    logic [CSUM_W-1:0]  csum;
    logic [FSLOT_W-1:0] slot;
    logic [FREED_W-1:0] freed;
    logic               last;
  } res_t;

endpackage

/* design/go_back_n_sender.sv */
// A payload byte or ack is taken when the controller is idle and the output
// register is free; a last byte or an ack shows its result beat on m_tvalid
// the next cycle. One byte or ack per cycle while s_tready is high; a timeout
// holds it low while each outstanding frame is fetched from the slot memory
// by a registered read and resent. Reset (rst, synchronous) empties the window
// and the packet sum and drops any held result; the slot memory is not cleared, only written slots are read.
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-back-N ARQ sender: sums packet bytes into a checksum, issues frame
// descriptors into a sliding window, frees frames on acks and resends the
// whole window on a timeout.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int WINDOW_DEPTH = gbn_pkg::DEF_WINDOW_DEPTH,
  parameter int SEQ_MAX      = gbn_pkg::DEF_SEQ_MAX,
  parameter int PAYLOAD_MAX  = gbn_pkg::DEF_PAYLOAD_MAX
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], ack_seq[10:8], ack_flag[11]
  input  logic [1:0]  s_tuser,   // op[1:0]
  input  logic        s_tlast,   // last_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // frame_seq[2:0], frame_checksum[19:3],
                                 // slot[21:20], freed[24:22]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  gbn_pkg::res_t               res;
  gbn_pkg::res_t               out_res;
  logic                        res_valid;
  logic                        res_ready;
  logic                        mem_we;
  logic [SLOT_W-1:0]           mem_waddr;
  logic [gbn_pkg::CSUM_W-1:0]  mem_wdata;
  logic [SLOT_W-1:0]           mem_raddr;
  logic [gbn_pkg::CSUM_W-1:0]  mem_rdata;

  gbn_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SEQ_MAX      (SEQ_MAX),
    .PAYLOAD_MAX  (PAYLOAD_MAX)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_data     (s_tdata[7:0]),
    .in_last     (s_tlast),
    .in_ack_seq  (s_tdata[10:8]),
    .in_ack_flag (s_tdata[11]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  gbn_slot_mem #(
    .DEPTH  (WINDOW_DEPTH),
    .DATA_W (gbn_pkg::CSUM_W)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: free when empty or when the held beat leaves
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'b0, out_res.freed, out_res.slot, out_res.csum, out_res.seq};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

/* design/gbn_slot_mem.sv */
// ----------------------------------------------------------------------------
// gbn_slot_mem
// Checksum store with one entry per window slot: one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module gbn_slot_mem #(
  parameter int DEPTH  = gbn_pkg::DEF_WINDOW_DEPTH,
  parameter int DATA_W = gbn_pkg::CSUM_W
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                      rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Store a checksum
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window state and sequencer: sums payload bytes, assigns sequence numbers
// and slots, handles acks, and walks the window on a timeout using one
// shared wrap-around incrementer.
// ----------------------------------------------------------------------------
module gbn_ctrl #(
  parameter int WINDOW_DEPTH = gbn_pkg::DEF_WINDOW_DEPTH,
  parameter int SEQ_MAX      = gbn_pkg::DEF_SEQ_MAX,
  parameter int PAYLOAD_MAX  = gbn_pkg::DEF_PAYLOAD_MAX,
  localparam int SLOT_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  // input item
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gbn_pkg::OP_W-1:0]     in_op,
  input  logic [gbn_pkg::BYTE_W-1:0]   in_data,
  input  logic                         in_last,
  input  logic [gbn_pkg::ASEQ_W-1:0]   in_ack_seq,
  input  logic                         in_ack_flag,
  // result toward the output register
  output logic                         res_valid,
  input  logic                         res_ready,
  output gbn_pkg::res_t                res,
  // slot memory
  output logic                         mem_we,
  output logic [SLOT_W-1:0]            mem_waddr,
  output logic [gbn_pkg::CSUM_W-1:0]   mem_wdata,
  output logic [SLOT_W-1:0]            mem_raddr,
  input  logic [gbn_pkg::CSUM_W-1:0]   mem_rdata
);

  localparam int SEQ_W = $clog2(SEQ_MAX + 1);
  localparam int OUT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = OUT_W + 1;
  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int CS_W  = gbn_pkg::CSUM_W;

  localparam logic [SEQ_W-1:0]  SEQ_LAST  = SEQ_W'(SEQ_MAX);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [OUT_W-1:0]  WIN_FULL  = OUT_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0]  WIN_WRAP  = SUM_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(PAYLOAD_MAX);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t            state;
  logic [SEQ_W-1:0]  base_seq;
  logic [SLOT_W-1:0] base_slot;
  logic [OUT_W-1:0]  outstanding;
  logic [SEQ_W-1:0]  tx_seq;
  logic [SLOT_W-1:0] next_slot;
  logic [CS_W-1:0]   sum_acc;
  logic [CNT_W-1:0]  byte_count;
  logic [SEQ_W-1:0]  walk_seq;
  logic [SLOT_W-1:0] walk_slot;
  logic [OUT_W-1:0]  walk_cnt;

  logic              accept;
  logic              walk_last;
  logic [SEQ_W-1:0]  inc_seq_in;
  logic [SEQ_W-1:0]  inc_seq_out;
  logic [SLOT_W-1:0] inc_slot_in;
  logic [SLOT_W-1:0] inc_slot_out;
  logic              byte_room;
  logic              win_room;
  logic [CS_W-1:0]   sum_new;
  logic [CS_W-1:0]   frame_csum;
  logic              aseq_ok;
  logic [SEQ_W-1:0]  ack_seq_n;
  logic [SEQ_W-1:0]  ack_off;
  logic              ack_hit;
  logic [OUT_W-1:0]  ack_n;
  logic [SUM_W-1:0]  ack_slot_sum;
  logic [SLOT_W-1:0] base_slot_ack;
  logic [SEQ_W-1:0]  base_seq_ack;
  logic [SUM_W-1:0]  chk_sum;
  logic [SLOT_W-1:0] chk_slot;

  assign in_ready  = (state == ST_IDLE) && res_ready;
  assign accept    = in_valid && in_ready;
  assign walk_last = (walk_cnt == outstanding);

  // Shared wrap-around incrementer: new frames while idle, the walk otherwise
  assign inc_seq_in   = (state == ST_IDLE) ? tx_seq : walk_seq;
  assign inc_slot_in  = (state == ST_IDLE) ? next_slot : walk_slot;
  assign inc_seq_out  = (inc_seq_in == SEQ_LAST) ? '0 : SEQ_W'(inc_seq_in + 1'b1);
  assign inc_slot_out = (inc_slot_in == SLOT_LAST) ? '0 : SLOT_W'(inc_slot_in + 1'b1);

  // Payload sum and frame checksum
  assign byte_room  = (byte_count < CNT_LIMIT);
  assign win_room   = (outstanding < WIN_FULL);
  assign sum_new    = byte_room ? CS_W'(sum_acc + CS_W'(in_data)) : sum_acc;
  assign frame_csum = CS_W'(sum_new + CS_W'(tx_seq));

  // Ack window test: offset from the oldest outstanding frame
  assign aseq_ok   = in_ack_flag && (32'(in_ack_seq) <= SEQ_MAX);
  assign ack_seq_n = SEQ_W'(in_ack_seq);
  assign ack_off   = (ack_seq_n >= base_seq) ? SEQ_W'(ack_seq_n - base_seq)
                   : SEQ_W'(32'(ack_seq_n) + SEQ_MAX + 1 - 32'(base_seq));
  assign ack_hit   = aseq_ok && (32'(ack_off) < 32'(outstanding));
  assign ack_n     = OUT_W'(32'(ack_off) + 1);

  // Advance the window base past the acked frame
  assign ack_slot_sum  = SUM_W'(base_slot) + SUM_W'(ack_n);
  assign base_slot_ack = (ack_slot_sum >= WIN_WRAP) ? SLOT_W'(ack_slot_sum - WIN_WRAP)
                       : SLOT_W'(ack_slot_sum);
  assign base_seq_ack  = (ack_seq_n == SEQ_LAST) ? '0 : SEQ_W'(ack_seq_n + 1'b1);

  // Slot memory ports
  assign mem_waddr = next_slot;
  assign mem_wdata = frame_csum;
  assign mem_raddr = walk_slot;

  // Build the result beat
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            gbn_pkg::OP_BYTE: begin
              if (in_last) begin
                res_valid = 1'b1;
                mem_we    = win_room;
                res.kind  = win_room ? gbn_pkg::KIND_SENT : gbn_pkg::KIND_DROP;
                res.seq   = gbn_pkg::FSEQ_W'(tx_seq);
                res.csum  = frame_csum;
                res.slot  = gbn_pkg::FSLOT_W'(next_slot);
                res.last  = 1'b1;
              end
            end
            gbn_pkg::OP_ACK: begin
              res_valid = 1'b1;
              res.kind  = ack_hit ? gbn_pkg::KIND_ACK_OK : gbn_pkg::KIND_ACK_IGN;
              res.seq   = in_ack_seq;
              res.freed = ack_hit ? gbn_pkg::FREED_W'(ack_n) : '0;
              res.last  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        res.kind  = gbn_pkg::KIND_SENT;
        res.seq   = gbn_pkg::FSEQ_W'(walk_seq);
        res.csum  = mem_rdata;
        res.slot  = gbn_pkg::FSLOT_W'(walk_slot);
        res.last  = walk_last;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      base_seq    <= '0;
      base_slot   <= '0;
      outstanding <= '0;
      tx_seq      <= '0;
      next_slot   <= '0;
      sum_acc     <= '0;
      byte_count  <= '0;
      walk_seq    <= '0;
      walk_slot   <= '0;
      walk_cnt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_op)
              gbn_pkg::OP_BYTE: begin
                if (in_last) begin
                  // close the packet; claim a slot if the window has room
                  sum_acc    <= '0;
                  byte_count <= '0;
                  if (win_room) begin
                    outstanding <= OUT_W'(outstanding + 1'b1);
                    tx_seq      <= inc_seq_out;
                    next_slot   <= inc_slot_out;
                  end
                end else begin
                  sum_acc <= sum_new;
                  if (byte_room) begin
                    byte_count <= CNT_W'(byte_count + 1'b1);
                  end
                end
              end
              gbn_pkg::OP_ACK: begin
                if (ack_hit) begin
                  base_seq    <= base_seq_ack;
                  base_slot   <= base_slot_ack;
                  outstanding <= OUT_W'(outstanding - ack_n);
                end
              end
              gbn_pkg::OP_TIMEOUT: begin
                if (outstanding != '0) begin
                  walk_seq  <= base_seq;
                  walk_slot <= base_slot;
                  walk_cnt  <= OUT_W'(1);
                  state     <= ST_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_ready) begin
            if (walk_last) begin
              state <= ST_IDLE;
            end else begin
              walk_seq  <= inc_seq_out;
              walk_slot <= inc_slot_out;
              walk_cnt  <= OUT_W'(walk_cnt + 1'b1);
              state     <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Expected next slot: oldest slot plus outstanding count, wrapped
  assign chk_sum  = SUM_W'(base_slot) + SUM_W'(outstanding);
  assign chk_slot = (chk_sum >= WIN_WRAP) ? SLOT_W'(chk_sum - WIN_WRAP) : SLOT_W'(chk_sum);

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= WIN_FULL)
    else $error("outstanding frame count exceeds window depth");

  a_next_slot: assert property (@(posedge clk) disable iff (rst)
    next_slot == chk_slot)
    else $error("next slot out of step with window base");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (outstanding != '0 && walk_cnt <= outstanding))
    else $error("window walk outside the outstanding frames");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && res_ready && walk_last) |=> (state == ST_IDLE))
    else $error("walk did not finish after the last resend");

endmodule
